// File: rtl/prc_pkg.sv
// Shared types and constants of the polygon ring centroid unit
`default_nettype none
package prc_pkg;
	typedef struct packed {
		logic [31:0] geom_word;
		logic        word_valid;
		logic        last_word;
		logic        is_polygon;
	} item_t;

	typedef struct packed {
		logic [1:0]         anchor_status;
		logic signed [23:0] centroid_x;
		logic signed [23:0] centroid_y;
	} result_t;

	typedef struct packed {
		logic        start;
		logic [63:0] sum;
		logic [63:0] area;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [23:0] quot;
	} div_rsp_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	localparam logic [2:0] CMD_MOVE  = 3'd1;
	localparam logic [2:0] CMD_LINE  = 3'd2;
	localparam logic [2:0] CMD_CLOSE = 3'd7;

	localparam int PADDR_BITS = 3;
	localparam logic REG_EXTENT = 1'b0;
	localparam logic REG_PIXELS = 1'b1;
	localparam logic [15:0] EXTENT_RESET = 16'd4096;
	localparam logic [12:0] PIXELS_RESET = 13'd512;

	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction
endpackage
`default_nettype wire

// File: rtl/polygon_ring_centroid_unit.sv
// Top level of the polygon ring centroid unit: register port, queue, ring engine, divider
//
// channel  | direction | handshake        | payload
// item     | in        | push / full      | item_t   (geom_word, word_valid, last_word, is_polygon)
// result   | out       | pop / empty      | result_t (anchor_status, centroid_x, centroid_y)
// config   | in/out    | APB psel/penable | tile_extent at 0x0, tile_pixels at 0x4
//
// A parameter word passes through the ring engine's idle and tail states; the second word of
// a pair after the first vertex also runs the shoelace edge, four passes through one multiplier.
// A ring close runs its closing edge the same way; the last item may then divide once per axis.
// A two-entry queue holds items while the engine works; one result register holds output.
// Reset restores both registers and clears all feature state at once.
`default_nettype none
module polygon_ring_centroid_unit import prc_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int VERT_COUNT_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire item_t                 item,
	output logic                       full,
	output logic                       empty,
	input  wire logic                  pop,
	output result_t                    result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_BITS-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	logic [15:0] extent_q;
	logic [12:0] pixels_q;
	logic [15:0] ext_eff;
	logic [17:0] mula;
	logic [20:0] mulp;
	logic        fvalid, ftake;
	item_t       fhead;
	div_req_t    dreq;
	div_rsp_t    drsp;

	assign pready  = 1'b1;
	assign prdata  = (paddr[2] == REG_PIXELS) ? 32'(pixels_q) : 32'(extent_q);
	assign ext_eff = (extent_q == 16'd0) ? 16'd1 : extent_q;
	assign mula    = 18'(ext_eff) * 18'd3;
	assign mulp    = {pixels_q, 8'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extent_q <= EXTENT_RESET;
			pixels_q <= PIXELS_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_EXTENT) extent_q <= pwdata[15:0];
			else pixels_q <= pwdata[12:0];
		end
	end

	prc_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .item(item), .full(full),
		.valid(fvalid), .take(ftake), .head(fhead)
	);

	prc_back #(.COORD_BITS(COORD_BITS), .VERT_COUNT_BITS(VERT_COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .valid(fvalid), .head(fhead), .take(ftake),
		.dreq(dreq), .drsp(drsp), .empty(empty), .pop(pop), .result(result)
	);

	prc_div u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .mulp(mulp), .mula(mula), .rsp(drsp)
	);

	a_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.anchor_status == ST_OK ||
			(result.centroid_x == 24'sd0 && result.centroid_y == 24'sd0)))
		else $error("centroid nonzero on a transaction without anchor");

	a_full_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("queue filled without a push");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.anchor_status == ST_OK || result.anchor_status == ST_NONE ||
			result.anchor_status == ST_OVF))
		else $error("undefined anchor status");
endmodule
`default_nettype wire

// File: rtl/prc_front.sv
// Input queue that accepts geometry items ahead of the ring engine
`default_nettype none
module prc_front import prc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t item,
	output logic       full,
	output logic       valid,
	input  wire logic  take,
	output item_t      head
);
	item_t      mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full    = (cnt_q == 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign head    = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = take && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule
`default_nettype wire

// File: rtl/prc_div.sv
// Scaled ratio unit: partial-product scaling and a bit-serial restoring divide
`default_nettype none
module prc_div import prc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire div_req_t    req,
	input  wire logic [20:0] mulp,
	input  wire logic [17:0] mula,
	output div_rsp_t         rsp
);
	typedef enum logic [7:0] {
		D_IDLE = 8'b0000_0001,
		D_NL   = 8'b0000_0010,
		D_NH   = 8'b0000_0100,
		D_DL   = 8'b0000_1000,
		D_DH   = 8'b0001_0000,
		D_CHK  = 8'b0010_0000,
		D_ITER = 8'b0100_0000,
		D_FIN  = 8'b1000_0000
	} dstate_t;

	dstate_t     state_q;
	logic [63:0] smag_q, amag_q;
	logic        neg_q, big_q;
	logic [84:0] num_q;
	logic [81:0] den_q;
	logic [82:0] rem_q;
	logic [31:0] low_q, quot_q;
	logic [4:0]  cnt_q;
	logic [31:0] m_a;
	logic [20:0] m_b;
	logic [52:0] prod;
	logic [83:0] rem2;
	logic        qbit;
	logic [31:0] lim, qsat;

	always_comb begin
		unique case (state_q)
			D_NL:    m_a = smag_q[31:0];
			D_NH:    m_a = smag_q[63:32];
			D_DL:    m_a = amag_q[31:0];
			default: m_a = amag_q[63:32];
		endcase
		m_b  = (state_q == D_NL || state_q == D_NH) ? mulp : 21'(mula);
		prod = 53'(m_a) * 53'(m_b);
		rem2 = {rem_q, low_q[31]};
		qbit = (rem2 >= 84'(den_q));
		lim  = neg_q ? 32'd8388608 : 32'd8388607;
		qsat = (big_q || quot_q > lim) ? lim : quot_q;
	end

	assign rsp.done = (state_q == D_FIN);
	assign rsp.quot = neg_q ? 24'(~qsat + 32'd1) : qsat[23:0];

	always_ff @(posedge clk) begin
		unique case (state_q)
			D_IDLE: begin
				smag_q <= mag64(req.sum);
				amag_q <= mag64(req.area);
				neg_q  <= req.sum[63] ^ req.area[63];
			end
			D_NL: num_q <= 85'(prod);
			D_NH: num_q <= num_q + (85'(prod) << 32);
			D_DL: den_q <= 82'(prod);
			D_DH: den_q <= den_q + (82'(prod) << 32);
			D_CHK: begin
				big_q <= (82'(num_q[84:32]) >= den_q);
				rem_q <= 83'(num_q[84:32]);
				low_q <= num_q[31:0];
			end
			D_ITER: begin
				rem_q  <= qbit ? 83'(rem2 - 84'(den_q)) : rem2[82:0];
				low_q  <= {low_q[30:0], 1'b0};
				quot_q <= {quot_q[30:0], qbit};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= 5'd0;
		end else begin
			unique case (state_q)
				D_IDLE: if (req.start) state_q <= D_NL;
				D_NL:   state_q <= D_NH;
				D_NH:   state_q <= D_DL;
				D_DL:   state_q <= D_DH;
				D_DH:   state_q <= D_CHK;
				D_CHK: begin
					cnt_q   <= 5'd0;
					state_q <= D_ITER;
				end
				D_ITER: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) state_q <= D_FIN;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/prc_back.sv
// Ring engine: parses words, accumulates shoelace sums, keeps best rings, emits result
`default_nettype none
module prc_back import prc_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int VERT_COUNT_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  valid,
	input  wire item_t head,
	output logic       take,
	output div_req_t   dreq,
	input  wire div_rsp_t drsp,
	output logic       empty,
	input  wire logic  pop,
	output result_t    result
);
	localparam int CB = COORD_BITS;
	localparam int VB = VERT_COUNT_BITS;
	localparam int AW = 2 * CB + 1;
	localparam int BW = CB + 1;
	localparam int PW = AW + BW;

	typedef enum logic [13:0] {
		S_IDLE = 14'b00_0000_0000_0001,
		S_TAIL = 14'b00_0000_0000_0010,
		S_FIN  = 14'b00_0000_0000_0100,
		S_E1   = 14'b00_0000_0000_1000,
		S_E2   = 14'b00_0000_0001_0000,
		S_E3   = 14'b00_0000_0010_0000,
		S_E4   = 14'b00_0000_0100_0000,
		S_BEST = 14'b00_0000_1000_0000,
		S_SEL  = 14'b00_0001_0000_0000,
		S_DX   = 14'b00_0010_0000_0000,
		S_DXW  = 14'b00_0100_0000_0000,
		S_DY   = 14'b00_1000_0000_0000,
		S_DYW  = 14'b01_0000_0000_0000,
		S_OUT  = 14'b10_0000_0000_0000
	} state_t;

	typedef enum logic [1:0] {PH_CMD, PH_DX, PH_DY} phase_t;

	state_t               state_q;
	phase_t               phase_q;
	item_t                cur_q;
	logic [28:0]          pairs_q;
	logic [31:0]          held_q;
	logic signed [CB-1:0] cx_q, cy_q, fx_q, fy_q, prx_q, pry_q;
	logic signed [CB-1:0] px_q, py_q, qx_q, qy_q;
	logic [VB-1:0]        verts_q;
	logic [63:0]          area_q, sx_q, sy_q;
	logic [63:0]          bo_a_q, bo_x_q, bo_y_q, ba_a_q, ba_x_q, ba_y_q;
	logic                 ovf_q, fin_last_q, to_best_q, res_valid_q;
	logic signed [63:0]   p1_q;
	logic signed [AW-1:0] cr_q;
	logic [1:0]           status_q;
	logic [23:0]          rx_q, ry_q;
	result_t              res_q;

	logic signed [AW-1:0] mul_a, cr_next;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] prod;
	logic signed [63:0]   prod64;
	logic signed [CB-1:0] nx, ny;
	logic                 ox, oy;
	logic [63:0]          sel_a, sel_x, sel_y, amag;
	logic [2:0]           cmd_id;
	logic [28:0]          cmd_cnt;

	function automatic logic signed [CB:0] move(input logic signed [CB-1:0] c,
		input logic [31:0] w);
		logic [31:0]          u;
		logic signed [33:0]   n;
		logic signed [CB-1:0] t;
		u = (w >> 1) ^ {32{w[0]}};
		n = 34'(c) + 34'(signed'(u));
		t = n[CB-1:0];
		return {(34'(t) != n), t};
	endfunction

	always_comb begin
		unique case (state_q)
			S_E1: begin
				mul_a = AW'(qy_q);
				mul_b = BW'(px_q);
			end
			S_E2: begin
				mul_a = AW'(py_q);
				mul_b = BW'(qx_q);
			end
			S_E3: begin
				mul_a = cr_q;
				mul_b = BW'(px_q) + BW'(qx_q);
			end
			default: begin
				mul_a = cr_q;
				mul_b = BW'(py_q) + BW'(qy_q);
			end
		endcase
		prod    = PW'(mul_a) * PW'(mul_b);
		prod64  = 64'(prod);
		cr_next = AW'(p1_q - prod64);
		{ox, nx} = move(cx_q, held_q);
		{oy, ny} = move(cy_q, head.geom_word);
		sel_a   = (bo_a_q != 64'd0) ? bo_a_q : ba_a_q;
		sel_x   = (bo_a_q != 64'd0) ? bo_x_q : ba_x_q;
		sel_y   = (bo_a_q != 64'd0) ? bo_y_q : ba_y_q;
		amag    = mag64(area_q);
		cmd_id  = head.geom_word[2:0];
		cmd_cnt = head.geom_word[31:3];
	end

	assign take       = (state_q == S_IDLE) && valid;
	assign dreq.start = (state_q == S_DX) || (state_q == S_DY);
	assign dreq.sum   = (state_q == S_DY) ? sel_y : sel_x;
	assign dreq.area  = sel_a;
	assign empty      = !res_valid_q;
	assign result     = res_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (valid) cur_q <= head;
			S_E1:   p1_q <= prod64;
			S_E2:   cr_q <= cr_next;
			S_SEL:  begin
				rx_q <= 24'd0;
				ry_q <= 24'd0;
			end
			S_DXW:  if (drsp.done) rx_q <= drsp.quot;
			S_DYW:  if (drsp.done) ry_q <= drsp.quot;
			S_OUT:  if (!res_valid_q || pop) begin
				res_q.anchor_status <= status_q;
				res_q.centroid_x    <= rx_q;
				res_q.centroid_y    <= ry_q;
			end
			default: begin
			end
		endcase
		if (state_q == S_IDLE && valid && head.word_valid && phase_q == PH_DY) begin
			px_q <= prx_q;
			py_q <= pry_q;
			qx_q <= nx;
			qy_q <= ny;
		end else if (state_q == S_FIN) begin
			px_q <= prx_q;
			py_q <= pry_q;
			qx_q <= fx_q;
			qy_q <= fy_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_CMD;
			pairs_q     <= '0;
			held_q      <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			fx_q        <= '0;
			fy_q        <= '0;
			prx_q       <= '0;
			pry_q       <= '0;
			verts_q     <= '0;
			area_q      <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			bo_a_q      <= '0;
			bo_x_q      <= '0;
			bo_y_q      <= '0;
			ba_a_q      <= '0;
			ba_x_q      <= '0;
			ba_y_q      <= '0;
			ovf_q       <= 1'b0;
			fin_last_q  <= 1'b0;
			to_best_q   <= 1'b0;
			res_valid_q <= 1'b0;
			status_q    <= ST_NONE;
		end else begin
			if (pop && res_valid_q && state_q != S_OUT) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (valid) begin
					state_q <= S_TAIL;
					if (head.word_valid) begin
						unique case (phase_q)
							PH_DX: begin
								held_q  <= head.geom_word;
								phase_q <= PH_DY;
							end
							PH_DY: begin
								cx_q    <= nx;
								cy_q    <= ny;
								prx_q   <= nx;
								pry_q   <= ny;
								ovf_q   <= ovf_q | ox | oy;
								pairs_q <= pairs_q - 29'd1;
								phase_q <= (pairs_q != 29'd1) ? PH_DX : PH_CMD;
								if (verts_q != '1) verts_q <= verts_q + VB'(1);
								if (verts_q == '0) begin
									fx_q <= nx;
									fy_q <= ny;
								end else begin
									to_best_q <= 1'b0;
									state_q   <= S_E1;
								end
							end
							default: begin
								if (cmd_id == CMD_MOVE || cmd_id == CMD_LINE) begin
									pairs_q <= cmd_cnt;
									phase_q <= (cmd_cnt != 29'd0) ? PH_DX : PH_CMD;
								end
								if (cmd_id == CMD_MOVE || cmd_id == CMD_CLOSE) begin
									state_q <= S_FIN;
								end
							end
						endcase
					end
				end
				S_TAIL: begin
					if (cur_q.last_word) begin
						fin_last_q <= 1'b1;
						state_q    <= S_FIN;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_FIN: begin
					if (verts_q >= VB'(3)) begin
						to_best_q <= 1'b1;
						state_q   <= S_E1;
					end else begin
						verts_q <= '0;
						area_q  <= '0;
						sx_q    <= '0;
						sy_q    <= '0;
						fx_q    <= '0;
						fy_q    <= '0;
						prx_q   <= '0;
						pry_q   <= '0;
						state_q <= fin_last_q ? S_SEL : S_TAIL;
					end
				end
				S_E1: state_q <= S_E2;
				S_E2: begin
					area_q  <= area_q + 64'(cr_next);
					state_q <= S_E3;
				end
				S_E3: begin
					sx_q    <= sx_q + prod64;
					state_q <= S_E4;
				end
				S_E4: begin
					sy_q    <= sy_q + prod64;
					state_q <= to_best_q ? S_BEST : S_TAIL;
				end
				S_BEST: begin
					if (area_q[63] && amag > mag64(bo_a_q)) begin
						bo_a_q <= area_q;
						bo_x_q <= sx_q;
						bo_y_q <= sy_q;
					end
					if (amag > mag64(ba_a_q)) begin
						ba_a_q <= area_q;
						ba_x_q <= sx_q;
						ba_y_q <= sy_q;
					end
					verts_q <= '0;
					area_q  <= '0;
					sx_q    <= '0;
					sy_q    <= '0;
					fx_q    <= '0;
					fy_q    <= '0;
					prx_q   <= '0;
					pry_q   <= '0;
					state_q <= fin_last_q ? S_SEL : S_TAIL;
				end
				S_SEL: begin
					priority if (!cur_q.is_polygon) begin
						status_q <= ST_NONE;
						state_q  <= S_OUT;
					end else if (ovf_q) begin
						status_q <= ST_OVF;
						state_q  <= S_OUT;
					end else if (sel_a != 64'd0) begin
						status_q <= ST_OK;
						state_q  <= S_DX;
					end else begin
						status_q <= ST_NONE;
						state_q  <= S_OUT;
					end
				end
				S_DX:  state_q <= S_DXW;
				S_DXW: if (drsp.done) state_q <= S_DY;
				S_DY:  state_q <= S_DYW;
				S_DYW: if (drsp.done) state_q <= S_OUT;
				default: begin
					if (!res_valid_q || pop) begin
						res_valid_q <= 1'b1;
						fin_last_q  <= 1'b0;
						phase_q     <= PH_CMD;
						pairs_q     <= '0;
						held_q      <= '0;
						cx_q        <= '0;
						cy_q        <= '0;
						bo_a_q      <= '0;
						bo_x_q      <= '0;
						bo_y_q      <= '0;
						ba_a_q      <= '0;
						ba_x_q      <= '0;
						ba_y_q      <= '0;
						ovf_q       <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// File: dv/testbench.sv
// Testbench of the polygon ring centroid unit: directed table, random features, anchor predictor
`timescale 1ns / 100ps
module testbench;
	import prc_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t res;
	} row_t;

	logic clk, arst_n, push, full, empty, pop;
	logic psel, penable, pwrite, pready;
	logic [PADDR_BITS-1:0] paddr;
	logic [31:0] pwdata, prdata;
	item_t item;
	result_t result;

	polygon_ring_centroid_unit u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .item(item), .full(full),
		.empty(empty), .pop(pop), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	int cycles = 0;
	int errors = 0;
	int items_sent = 0;
	int burst_left = 0;
	bit hold_request = 0;
	result_t anchor_q[$];
	row_t directed_rows[$];

	// predictor state
	logic [15:0] cfg_extent;
	logic [12:0] cfg_pixels;
	longint cur_x, cur_y, first_x, first_y, prev_x, prev_y;
	int unsigned phase, pairs_left, verts;
	logic [31:0] held_dx;
	logic [63:0] ring_area, ring_sx, ring_sy;
	logic [63:0] neg_area, neg_sx, neg_sy, big_area, big_sx, big_sy;
	bit coord_ovf;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (anchor_q.size() == 0) begin
				report("unexpected transaction", 32'(result.anchor_status), 32'd0);
			end else begin
				result_t want;
				want = anchor_q.pop_front();
				if (result.anchor_status !== want.anchor_status)
					report("anchor_status", 32'(result.anchor_status),
						32'(want.anchor_status));
				if (result.centroid_x !== want.centroid_x)
					report("centroid_x", 32'(result.centroid_x), 32'(want.centroid_x));
				if (result.centroid_y !== want.centroid_y)
					report("centroid_y", 32'(result.centroid_y), 32'(want.centroid_y));
			end
		end
	end

	function automatic logic [63:0] abs64(input logic [63:0] v);
		return v[63] ? -v : v;
	endfunction

	function automatic logic [31:0] zz(input int d);
		return (d <<< 1) ^ (d >>> 31);
	endfunction

	function void clear_ring();
		first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
		verts = 0;
		ring_area = 0; ring_sx = 0; ring_sy = 0;
	endfunction

	function void clear_feature();
		cur_x = 0; cur_y = 0;
		phase = 0; pairs_left = 0; held_dx = 0;
		clear_ring();
		neg_area = 0; neg_sx = 0; neg_sy = 0;
		big_area = 0; big_sx = 0; big_sy = 0;
		coord_ovf = 0;
	endfunction

	function void add_edge(input longint px, py, qx, qy);
		logic [63:0] cr;
		cr = px * qy - qx * py;
		ring_area += cr;
		ring_sx += (px + qx) * cr;
		ring_sy += (py + qy) * cr;
	endfunction

	function void close_ring();
		logic [63:0] m;
		if (verts >= 3) begin
			add_edge(prev_x, prev_y, first_x, first_y);
			m = abs64(ring_area);
			if (ring_area[63] && m > abs64(neg_area)) begin
				neg_area = ring_area; neg_sx = ring_sx; neg_sy = ring_sy;
			end
			if (m > abs64(big_area)) begin
				big_area = ring_area; big_sx = ring_sx; big_sy = ring_sy;
			end
		end
		clear_ring();
	endfunction

	function longint step_axis(input longint c, input logic [31:0] w);
		logic [31:0] u;
		longint n;
		u = {1'b0, w[31:1]} ^ {32{w[0]}};
		n = c + longint'(signed'(u));
		if (n > 32767 || n < -32768)
			coord_ovf = 1;
		return longint'(signed'(n[15:0]));
	endfunction

	function void take_word(input logic [31:0] w);
		if (phase == 1) begin
			held_dx = w;
			phase = 2;
		end else if (phase == 2) begin
			cur_x = step_axis(cur_x, held_dx);
			cur_y = step_axis(cur_y, w);
			if (verts == 0) begin
				first_x = cur_x; first_y = cur_y;
			end else begin
				add_edge(prev_x, prev_y, cur_x, cur_y);
			end
			prev_x = cur_x; prev_y = cur_y;
			if (verts < 65535)
				verts++;
			pairs_left--;
			phase = pairs_left ? 1 : 0;
		end else begin
			if (w[2:0] == CMD_MOVE)
				close_ring();
			if (w[2:0] == CMD_MOVE || w[2:0] == CMD_LINE) begin
				pairs_left = w[31:3];
				phase = pairs_left ? 1 : 0;
			end else if (w[2:0] == CMD_CLOSE) begin
				close_ring();
			end
		end
	endfunction

	function automatic logic [23:0] centroid_axis(input logic [63:0] s, input logic [63:0] a,
			input logic [15:0] ext, input logic [12:0] pix);
		logic [127:0] num, den, q;
		bit neg;
		num = 128'(abs64(s)) * 128'({pix, 8'd0});
		den = 128'(abs64(a)) * 128'(3 * ((ext == 0) ? 17'd1 : {1'b0, ext}));
		q = num / den;
		neg = s[63] ^ a[63];
		if (q > (neg ? 128'd8388608 : 128'd8388607))
			q = neg ? 128'd8388608 : 128'd8388607;
		if (neg)
			q = -q;
		return q[23:0];
	endfunction

	function void predict(input item_t it, input bit typed, input result_t typed_res);
		result_t r;
		if (it.word_valid)
			take_word(it.geom_word);
		if (it.last_word) begin
			close_ring();
			r = '{ST_NONE, 24'sd0, 24'sd0};
			if (!it.is_polygon) begin
				r.anchor_status = ST_NONE;
			end else if (coord_ovf) begin
				r.anchor_status = ST_OVF;
			end else if (neg_area != 0) begin
				r = '{ST_OK, centroid_axis(neg_sx, neg_area, cfg_extent, cfg_pixels),
					centroid_axis(neg_sy, neg_area, cfg_extent, cfg_pixels)};
			end else if (big_area != 0) begin
				r = '{ST_OK, centroid_axis(big_sx, big_area, cfg_extent, cfg_pixels),
					centroid_axis(big_sy, big_area, cfg_extent, cfg_pixels)};
			end
			anchor_q.insert(anchor_q.size(), typed ? typed_res : r);
			clear_feature();
		end
	endfunction

	task automatic send(input item_t it, input bit typed = 0, input result_t tr = '0);
		if (burst_left == 0) begin
			push = 0;
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		item = it;
		push = 1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict(it, typed, tr);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [15:0] ext, input logic [12:0] pix);
		push = 0;
		while (anchor_q.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		for (int r = 0; r < 2; r++) begin
			psel = 1; pwrite = 1; penable = 0;
			paddr = (r == 0) ? PADDR_BITS'(4 * REG_EXTENT) : PADDR_BITS'(4 * REG_PIXELS);
			pwdata = (r == 0) ? {16'd0, ext} : {19'd0, pix};
			@(negedge clk);
			penable = 1;
			@(posedge clk);
			while (!pready)
				@(posedge clk);
			@(negedge clk);
			psel = 0; penable = 0;
		end
		cfg_extent = ext;
		cfg_pixels = pix;
	endtask

	function automatic item_t mk(input logic [31:0] w, input bit v = 1, l = 0, p = 1);
		return '{w, v, l, p};
	endfunction

	task automatic rand_feature();
		item_t feat[$];
		int kind, amp, nv;
		kind = $urandom_range(0, 99);
		amp = (kind < 30) ? 3 : (kind < 80) ? 150 : 2500;
		repeat ($urandom_range(1, 3)) begin
			nv = $urandom_range(1, 7);
			feat = {feat, mk({29'd1, CMD_MOVE})};
			for (int i = 0; i < nv; i++) begin
				if (i == 1)
					feat = {feat, mk({29'(nv - 1), CMD_LINE})};
				if (kind >= 95) begin
					feat = {feat, mk($urandom())};
					feat = {feat, mk($urandom())};
				end else begin
					feat = {feat, mk(zz($urandom_range(0, 2 * amp) - amp))};
					feat = {feat, mk(zz($urandom_range(0, 2 * amp) - amp))};
				end
				if ($urandom_range(0, 30) == 0)
					feat = {feat, mk($urandom(), $urandom_range(0, 1))};
				if ($urandom_range(0, 40) == 0)
					feat = {feat, mk({29'd0, CMD_LINE})};
			end
			if ($urandom_range(0, 9) < 7)
				feat = {feat, mk({29'($urandom()), CMD_CLOSE})};
		end
		if ($urandom_range(0, 1))
			feat = {feat, mk($urandom(), 0)};
		feat[$].last_word = 1;
		feat[$].is_polygon = ($urandom_range(0, 14) != 0);
		foreach (feat[i])
			send(feat[i]);
	endtask

	initial begin
		logic [15:0] ext_set[6] = '{16'd4096, 16'd1, 16'd65535, 16'd0, 16'd16, 16'd4096};
		logic [12:0] pix_set[6] = '{13'd512, 13'd4096, 13'd1, 13'd0, 13'd256, 13'd8191};
		arst_n = 0; push = 0; pop = 0; item = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		cfg_extent = EXTENT_RESET; cfg_pixels = PIXELS_RESET;
		clear_feature();
		repeat (9) @(negedge clk);
		arst_n = 1;

		directed_rows = '{
			'{mk(0, 0, 1, 1), 1, '{ST_NONE, 0, 0}},
			'{mk(0, 0, 1, 0), 1, '{ST_NONE, 0, 0}},
			'{mk({29'd1, CMD_MOVE}), 0, '0}, '{mk(0), 0, '0}, '{mk(0), 0, '0},
			'{mk({29'd2, CMD_LINE}), 0, '0}, '{mk(zz(10)), 0, '0}, '{mk(0), 0, '0},
			'{mk(0), 0, '0}, '{mk(zz(10)), 0, '0},
			'{mk({29'd5, CMD_CLOSE}, 1, 1, 1), 0, '0},
			'{mk({29'd1, CMD_MOVE}), 0, '0}, '{mk(32'hFFFFFFFF), 0, '0},
			'{mk(32'hFFFFFFFE), 0, '0}, '{mk(0, 0, 1, 0), 1, '{ST_NONE, 0, 0}},
			'{mk({29'd1, CMD_MOVE}), 0, '0}, '{mk(zz(40000)), 0, '0},
			'{mk(0, 1, 1, 1), 1, '{ST_OVF, 0, 0}},
			'{mk({29'd4, 3'd3}), 0, '0}, '{mk({29'd0, CMD_LINE}), 0, '0},
			'{mk({29'd1, CMD_MOVE}), 0, '0}, '{mk(zz(5), 1, 1, 1), 1, '{ST_NONE, 0, 0}}
		};
		foreach (directed_rows[i])
			send(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);

		for (int s = 0; s < 6; s++) begin
			cfg_write(ext_set[s], (s == 5) ? 13'($urandom_range(1, 4096)) : pix_set[s]);
			if (s == 0)
				hold_request = 1;
			while (items_sent < 22 + (s + 1) * 140)
				rand_feature();
		end
		push = 0;
		while (anchor_q.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int hold_left, mode_left, mode;
		hold_left = 0; mode_left = 0; mode = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 0;
				hold_left = 400;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				pop = 0;
			end else begin
				case (mode)
					0: pop = 1;
					1: pop = $urandom_range(0, 1);
					default: pop = ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end
endmodule
